// ===== rtl/grg_pkg.sv =====
// shared constants and types of the givens rotation generator
`timescale 1ns / 1ps

package grg_pkg;

    localparam int DATA_W      = 16;            // input and coefficient width
    localparam int SQ_W        = 32;            // squares, their sum and remainders
    localparam int DIV_STEPS   = 31;            // quotient bits of num^2 * 2^30 / rsq
    localparam int SQRT_STEPS  = 16;            // root bits of the quotient
    localparam int LANE_STAGES = DIV_STEPS + SQRT_STEPS;
    // abs, square, sum, lane stages, sign stage
    localparam int PIPE_STAGES = 3 + LANE_STAGES + 1;

    localparam logic signed [DATA_W-1:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic z_zero;     // z is zero: identity rotation
        logic swap;       // |z| > |x|
        logic opposite;   // x and z differ in sign
    } grg_flags_t;

endpackage

// ===== rtl/grg_ratio_lane.sv =====
// pipelined floor(sqrt(num_sq * 2^30 / rsq)) by restoring division then restoring root
`timescale 1ns / 1ps

module grg_ratio_lane import grg_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [SQ_W-1:0]       num_sq,
    input  logic [SQ_W-1:0]       rsq,
    output logic [SQRT_STEPS-1:0] root
);

    logic [SQ_W-1:0]       div_rem_reg [DIV_STEPS];
    logic [SQ_W-1:0]       div_rsq_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0]  div_q_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0]  sq_rem_reg  [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sq_res_reg  [SQRT_STEPS];

    // division: one quotient bit per stage, msb first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [SQ_W-1:0]      rem_in;
        logic [SQ_W-1:0]      rsq_in;
        logic [DIV_STEPS-1:0] q_in;
        logic                 take;

        if (k == 0) begin : g_first
            assign rem_in = num_sq;
            assign rsq_in = rsq;
            assign q_in   = '0;
        end else begin : g_next
            // remainder stays below rsq, so its top bit is free
            assign rem_in = {div_rem_reg[k-1][SQ_W-2:0], 1'b0};
            assign rsq_in = div_rsq_reg[k-1];
            assign q_in   = div_q_reg[k-1];
        end

        assign take = (rem_in >= rsq_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_rem_reg[k] <= take ? (rem_in - rsq_in) : rem_in;
                div_rsq_reg[k] <= rsq_in;
                div_q_reg[k]   <= q_in | (DIV_STEPS'(take) << (DIV_STEPS - 1 - k));
            end
        end
    end

    // integer square root: one root bit per stage, msb first
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam int K = SQRT_STEPS - 1 - j;
        logic [DIV_STEPS-1:0]  rem_in;
        logic [SQRT_STEPS-1:0] res_in;
        logic [SQ_W-1:0]       trial;
        logic                  take;

        if (j == 0) begin : g_first
            assign rem_in = div_q_reg[DIV_STEPS-1];
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = sq_rem_reg[j-1];
            assign res_in = sq_res_reg[j-1];
        end

        // (res + 2^k)^2 - res^2
        assign trial = (SQ_W'(res_in) << (K + 1)) | (SQ_W'(1) << (2 * K));
        assign take  = (SQ_W'(rem_in) >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[j] <= take ? DIV_STEPS'(SQ_W'(rem_in) - trial) : rem_in;
                sq_res_reg[j] <= res_in | (SQRT_STEPS'(take) << K);
            end
        end
    end

    assign root = sq_res_reg[SQRT_STEPS-1];

endmodule

// ===== rtl/givens_rotation_generator.sv =====
// top level of the givens rotation coefficient generator
`timescale 1ns / 1ps
// throughput: one word per cycle when not stalled; all 51 stages are registered and each takes a word per cycle
// a stall freezes the pipeline only when its last stage and the output register are both full
// and m_axis_tready is low
// reset clears the valid bits and the output register valid; data registers are not reset

module givens_rotation_generator import grg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input word
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] x_value, [31:16] z_value
    // result word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] cos_coef, [31:16] sin_coef
);

    // advance: hold only when the sign stage and output register are full and m_axis_tready is low
    logic adv;

    logic                     valid_reg [PIPE_STAGES];
    grg_flags_t               flags_reg [PIPE_STAGES];
    grg_flags_t               flags_next;

    // stage 0: magnitudes and selection flags
    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] z_in;
    logic [DATA_W-1:0]        ax_next;
    logic [DATA_W-1:0]        az_next;
    logic [DATA_W-1:0]        ax_reg;
    logic [DATA_W-1:0]        az_reg;

    // stage 1: squares
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqz_reg;

    // stage 2: sum of squares
    logic [SQ_W-1:0]          sum_sqx_reg;
    logic [SQ_W-1:0]          sum_sqz_reg;
    logic [SQ_W-1:0]          rsq_reg;

    // lane results: floor(32768 * |num| / r)
    logic [SQRT_STEPS-1:0]    root_x;
    logic [SQRT_STEPS-1:0]    root_z;

    // sign stage
    logic [DATA_W-1:0]        mag_x;
    logic [DATA_W-1:0]        mag_z;
    logic signed [DATA_W-1:0] cos_next;
    logic signed [DATA_W-1:0] sin_next;
    logic signed [DATA_W-1:0] cos_reg;
    logic signed [DATA_W-1:0] sin_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_cos_reg;
    logic signed [DATA_W-1:0] out_sin_reg;

    assign adv           = !(valid_reg[PIPE_STAGES-1] && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = adv;

    assign x_in = s_axis_tdata[DATA_W-1:0];
    assign z_in = s_axis_tdata[2*DATA_W-1:DATA_W];

    // two's complement magnitude, the most negative value maps to 32768 unsigned
    assign ax_next = x_in[DATA_W-1] ? DATA_W'(-x_in) : DATA_W'(x_in);
    assign az_next = z_in[DATA_W-1] ? DATA_W'(-z_in) : DATA_W'(z_in);

    always_comb
    begin
        flags_next.z_zero   = (z_in == '0);
        flags_next.swap     = (az_next > ax_next);
        flags_next.opposite = x_in[DATA_W-1] ^ z_in[DATA_W-1];
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // selection flags follow the same path, no reset needed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flags_reg[0] <= flags_next;
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                flags_reg[i] <= flags_reg[i-1];
            end
        end
    end

    // front end: magnitudes, squares, sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg      <= ax_next;
            az_reg      <= az_next;
            sqx_reg     <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqz_reg     <= SQ_W'(az_reg) * SQ_W'(az_reg);
            sum_sqx_reg <= sqx_reg;
            sum_sqz_reg <= sqz_reg;
            rsq_reg     <= sqx_reg + sqz_reg;
        end
    end

    // one lane for each coefficient magnitude
    grg_ratio_lane u_lane_x
    (
        .clk    (clk),
        .en     (adv),
        .num_sq (sum_sqx_reg),
        .rsq    (rsq_reg),
        .root   (root_x)
    );

    grg_ratio_lane u_lane_z
    (
        .clk    (clk),
        .en     (adv),
        .num_sq (sum_sqz_reg),
        .rsq    (rsq_reg),
        .root   (root_z)
    );

    // round to nearest: floor((w + 1) / 2) with w = floor(32768 * num / r)
    assign mag_x = DATA_W'((17'(root_x) + 17'd1) >> 1);
    assign mag_z = DATA_W'((17'(root_z) + 17'd1) >> 1);

    // apply signs; the flags here line up with the lane outputs
    always_comb
    begin
        if (flags_reg[PIPE_STAGES-2].z_zero)
        begin
            cos_next = ONE_Q14;
            sin_next = '0;
        end
        else if (flags_reg[PIPE_STAGES-2].swap)
        begin
            cos_next = flags_reg[PIPE_STAGES-2].opposite ? signed'(mag_x) : -signed'(mag_x);
            sin_next = signed'(mag_z);
        end
        else
        begin
            cos_next = signed'(mag_x);
            sin_next = flags_reg[PIPE_STAGES-2].opposite ? signed'(mag_z) : -signed'(mag_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    // output register parts the result side from the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= valid_reg[PIPE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || m_axis_tready) && valid_reg[PIPE_STAGES-1])
        begin
            out_cos_reg <= cos_reg;
            out_sin_reg <= sin_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_sin_reg, out_cos_reg};

endmodule
